FILE: sv/bml_pkg.sv
// shared types, constants and byte decode functions for the bracket matching lexer
// depends on nothing; used by the interfaces, the controller, the datapath and the top level
package bml_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int INDEX_BITS  = 16;
    localparam int SP_BITS     = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_BITS   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_AT      = 8'h40;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    localparam logic [15:0] SAT16 = 16'hFFFF;

    typedef enum logic [2:0] {
        ST_TOKEN           = 3'd0,
        ST_UNMATCHED_CLOSE = 3'd1,
        ST_TOO_DEEP        = 3'd2,
        ST_UNMATCHED_OPEN  = 3'd3,
        ST_END_DONE        = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        CMD_PLUS  = 4'd0,
        CMD_MINUS = 4'd1,
        CMD_LEFT  = 4'd2,
        CMD_RIGHT = 4'd3,
        CMD_IN    = 4'd4,
        CMD_OUT   = 4'd5,
        CMD_AT    = 4'd6,
        CMD_OPEN  = 4'd7,
        CMD_CLOSE = 4'd8
    } t_cmd;

    typedef enum logic [2:0] {
        C_NONE,
        C_NEWLINE,
        C_RUN,
        C_OPEN,
        C_CLOSE
    } t_class;

    typedef enum logic [1:0] {
        E_FLUSH,
        E_BRACKET,
        E_OPEN_LEFT,
        E_DONE
    } t_emit_sel;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_FLUSH,
        S_TOKEN,
        S_WALK_RD,
        S_WALK_EMIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic       kind;
        logic [7:0] source_byte;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        t_cmd        command;
        logic [15:0] repeat_count;
        logic [15:0] token_index;
        logic [15:0] partner_index;
        logic [15:0] line_number;
        logic [15:0] column;
        logic        last_result;
    } t_out_item;

    typedef struct packed {
        logic [INDEX_BITS-1:0] index;
        logic [15:0]           line;
        logic [15:0]           col;
    } t_stack_entry;

    // controller to datapath
    typedef struct packed {
        logic      latch_in;
        logic      newline;
        logic      col_inc;
        logic      merge;
        logic      load_pend;
        logic      emit;
        t_emit_sel emit_sel;
        logic      emit_last;
        logic      push;
        logic      pop;
        logic      set_fail;
        logic      walk_clr;
        logic      walk_inc;
        logic      walk_sel;
        logic      clear_all;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic   kind;
        logic   failed;
        t_class cls;
        logic   can_merge;
        logic   pend_valid;
        logic   stack_empty;
        logic   stack_full;
        logic   walk_last;
        logic   out_free;
    } t_dp_sts;

    function automatic t_class byte_class(input logic [7:0] b);
        t_class c;
        c = C_NONE;
        case (b)
            CH_PLUS, CH_MINUS, CH_LT, CH_GT, CH_COMMA, CH_DOT, CH_AT: c = C_RUN;
            CH_LBRACK:  c = C_OPEN;
            CH_RBRACK:  c = C_CLOSE;
            CH_NEWLINE: c = C_NEWLINE;
            default:    c = C_NONE;
        endcase
        return c;
    endfunction

    function automatic t_cmd byte_cmd(input logic [7:0] b);
        t_cmd c;
        c = CMD_PLUS;
        case (b)
            CH_PLUS:   c = CMD_PLUS;
            CH_MINUS:  c = CMD_MINUS;
            CH_LT:     c = CMD_LEFT;
            CH_GT:     c = CMD_RIGHT;
            CH_COMMA:  c = CMD_IN;
            CH_DOT:    c = CMD_OUT;
            CH_AT:     c = CMD_AT;
            CH_LBRACK: c = CMD_OPEN;
            CH_RBRACK: c = CMD_CLOSE;
            default:   c = CMD_PLUS;
        endcase
        return c;
    endfunction

endpackage

FILE: sv/bml_in_if.sv
// valid/ready channel carrying one source item (byte or end marker)
// depends on bml_pkg
interface bml_in_if;
    logic               valid;
    logic               ready;
    bml_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/bml_out_if.sv
// valid/ready channel carrying one lexer result
// depends on bml_pkg
interface bml_out_if;
    logic               valid;
    logic               ready;
    bml_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/bml_ctrl.sv
// sequencing state machine for the lexer: walks one item through decode, flush,
// bracket and end-of-source stack walk; depends on bml_pkg
module bml_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  bml_pkg::t_dp_sts i_sts,
    output bml_pkg::t_dp_cmd o_cmd
);

    bml_pkg::t_state r_state;
    bml_pkg::t_state n_state;

    logic flush_go;

    assign flush_go = !i_sts.pend_valid || i_sts.out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bml_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bml_pkg::S_IDLE: begin
                if (i_in_valid) n_state = bml_pkg::S_DECODE;
            end
            bml_pkg::S_DECODE: begin
                if (i_sts.kind) begin
                    n_state = i_sts.failed ? bml_pkg::S_DONE : bml_pkg::S_FLUSH;
                end else if (i_sts.failed) begin
                    n_state = bml_pkg::S_IDLE;
                end else begin
                    case (i_sts.cls)
                        bml_pkg::C_RUN: begin
                            n_state = i_sts.can_merge ? bml_pkg::S_IDLE : bml_pkg::S_FLUSH;
                        end
                        bml_pkg::C_OPEN, bml_pkg::C_CLOSE: n_state = bml_pkg::S_FLUSH;
                        default: n_state = bml_pkg::S_IDLE;
                    endcase
                end
            end
            bml_pkg::S_FLUSH: begin
                if (flush_go) begin
                    if (i_sts.kind) begin
                        n_state = i_sts.stack_empty ? bml_pkg::S_DONE : bml_pkg::S_WALK_RD;
                    end else if (i_sts.cls == bml_pkg::C_RUN) begin
                        n_state = bml_pkg::S_IDLE;
                    end else begin
                        n_state = bml_pkg::S_TOKEN;
                    end
                end
            end
            bml_pkg::S_TOKEN: begin
                if (i_sts.out_free) n_state = bml_pkg::S_IDLE;
            end
            bml_pkg::S_WALK_RD: begin
                n_state = bml_pkg::S_WALK_EMIT;
            end
            bml_pkg::S_WALK_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = i_sts.walk_last ? bml_pkg::S_DONE : bml_pkg::S_WALK_RD;
                end
            end
            bml_pkg::S_DONE: begin
                if (i_sts.out_free) n_state = bml_pkg::S_IDLE;
            end
            default: n_state = bml_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            bml_pkg::S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.latch_in = i_in_valid;
            end
            bml_pkg::S_DECODE: begin
                o_cmd.walk_clr = 1'b1;
                if (!i_sts.kind && !i_sts.failed) begin
                    case (i_sts.cls)
                        bml_pkg::C_NEWLINE: o_cmd.newline = 1'b1;
                        bml_pkg::C_NONE:    o_cmd.col_inc = 1'b1;
                        bml_pkg::C_RUN: begin
                            o_cmd.merge   = i_sts.can_merge;
                            o_cmd.col_inc = i_sts.can_merge;
                        end
                        default: o_cmd.col_inc = 1'b0;
                    endcase
                end
            end
            bml_pkg::S_FLUSH: begin
                if (flush_go) begin
                    o_cmd.emit     = i_sts.pend_valid;
                    o_cmd.emit_sel = bml_pkg::E_FLUSH;
                    // a new run start: the flushed token is this byte's only result
                    if (!i_sts.kind && i_sts.cls == bml_pkg::C_RUN) begin
                        o_cmd.emit_last = 1'b1;
                        o_cmd.load_pend = 1'b1;
                        o_cmd.col_inc   = 1'b1;
                    end
                end
            end
            bml_pkg::S_TOKEN: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_sel  = bml_pkg::E_BRACKET;
                    o_cmd.emit_last = 1'b1;
                    o_cmd.col_inc   = 1'b1;
                    if (i_sts.cls == bml_pkg::C_OPEN) begin
                        o_cmd.push     = !i_sts.stack_full;
                        o_cmd.set_fail = i_sts.stack_full;
                    end else begin
                        o_cmd.pop      = !i_sts.stack_empty;
                        o_cmd.set_fail = i_sts.stack_empty;
                    end
                end
            end
            bml_pkg::S_WALK_RD: begin
                o_cmd.walk_sel = 1'b1;
            end
            bml_pkg::S_WALK_EMIT: begin
                o_cmd.walk_sel = 1'b1;
                if (i_sts.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = bml_pkg::E_OPEN_LEFT;
                    o_cmd.walk_inc = 1'b1;
                end
            end
            bml_pkg::S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_sel  = bml_pkg::E_DONE;
                    o_cmd.emit_last = 1'b1;
                    o_cmd.clear_all = 1'b1;
                end
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

FILE: sv/bml_dp.sv
// lexer datapath: pending run, position counters, open bracket stack memory,
// token index counter and the result register; depends on bml_pkg
module bml_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bml_pkg::t_in_item  i_in_data,
    input  bml_pkg::t_dp_cmd   i_cmd,
    output bml_pkg::t_dp_sts   o_sts,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output bml_pkg::t_out_item o_out_data
);

    localparam int IB = bml_pkg::INDEX_BITS;
    localparam int SB = bml_pkg::SP_BITS;
    localparam int AB = bml_pkg::ADDR_BITS;

    logic                  r_kind;
    logic [7:0]            r_byte;
    logic                  r_pend_valid, n_pend_valid;
    logic [2:0]            r_pend_cmd, n_pend_cmd;
    logic [15:0]           r_pend_cnt, n_pend_cnt;
    logic [15:0]           r_pend_line, n_pend_line;
    logic [15:0]           r_pend_col, n_pend_col;
    logic [15:0]           r_line, n_line;
    logic [15:0]           r_col, n_col;
    logic [IB-1:0]         r_next_idx, n_next_idx;
    logic [SB-1:0]         r_sp, n_sp;
    logic [SB-1:0]         r_walk, n_walk;
    logic                  r_failed, n_failed;
    logic                  r_out_valid, n_out_valid;
    bml_pkg::t_out_item    r_out, n_out;
    bml_pkg::t_stack_entry r_rd_data;
    bml_pkg::t_stack_entry mem [bml_pkg::STACK_DEPTH];

    bml_pkg::t_class cur_cls;
    bml_pkg::t_cmd   cur_cmd;
    logic            is_open;
    logic            stack_empty;
    logic            stack_full;
    logic            bracket_err;
    logic            out_free;
    logic [AB-1:0]   rd_addr;

    assign cur_cls     = bml_pkg::byte_class(r_byte);
    assign cur_cmd     = bml_pkg::byte_cmd(r_byte);
    assign is_open     = (cur_cls == bml_pkg::C_OPEN);
    assign stack_empty = (r_sp == '0);
    assign stack_full  = (r_sp == SB'(bml_pkg::STACK_DEPTH));
    assign bracket_err = is_open ? stack_full : stack_empty;
    assign out_free    = !r_out_valid || i_out_ready;
    assign rd_addr     = i_cmd.walk_sel ? r_walk[AB-1:0] : AB'(r_sp - SB'(1));

    always_comb begin
        o_sts.kind        = r_kind;
        o_sts.failed      = r_failed;
        o_sts.cls         = cur_cls;
        o_sts.can_merge   = r_pend_valid && (r_pend_cmd == 3'(cur_cmd))
                            && (r_pend_cnt != bml_pkg::SAT16);
        o_sts.pend_valid  = r_pend_valid;
        o_sts.stack_empty = stack_empty;
        o_sts.stack_full  = stack_full;
        o_sts.walk_last   = ((r_walk + SB'(1)) == r_sp);
        o_sts.out_free    = out_free;
    end

    // result payload
    always_comb begin
        n_out             = r_out;
        n_out.last_result = i_cmd.emit_last;
        case (i_cmd.emit_sel)
            bml_pkg::E_FLUSH: begin
                n_out.status        = bml_pkg::ST_TOKEN;
                n_out.command       = bml_pkg::t_cmd'({1'b0, r_pend_cmd});
                n_out.repeat_count  = r_pend_cnt;
                n_out.token_index   = 16'(r_next_idx);
                n_out.partner_index = '0;
                n_out.line_number   = r_pend_line;
                n_out.column        = r_pend_col;
            end
            bml_pkg::E_BRACKET: begin
                n_out.command      = is_open ? bml_pkg::CMD_OPEN : bml_pkg::CMD_CLOSE;
                n_out.repeat_count = 16'd1;
                n_out.line_number  = r_line;
                n_out.column       = r_col;
                if (bracket_err) begin
                    n_out.status        = is_open ? bml_pkg::ST_TOO_DEEP
                                                  : bml_pkg::ST_UNMATCHED_CLOSE;
                    n_out.token_index   = '0;
                    n_out.partner_index = '0;
                end else begin
                    n_out.status        = bml_pkg::ST_TOKEN;
                    n_out.token_index   = 16'(r_next_idx);
                    n_out.partner_index = is_open ? 16'(r_next_idx) : 16'(r_rd_data.index);
                end
            end
            bml_pkg::E_OPEN_LEFT: begin
                n_out.status        = bml_pkg::ST_UNMATCHED_OPEN;
                n_out.command       = bml_pkg::CMD_OPEN;
                n_out.repeat_count  = 16'd1;
                n_out.token_index   = 16'(r_rd_data.index);
                n_out.partner_index = 16'(r_rd_data.index);
                n_out.line_number   = r_rd_data.line;
                n_out.column        = r_rd_data.col;
            end
            default: begin
                n_out.status        = bml_pkg::ST_END_DONE;
                n_out.command       = bml_pkg::CMD_PLUS;
                n_out.repeat_count  = '0;
                n_out.token_index   = '0;
                n_out.partner_index = '0;
                n_out.line_number   = '0;
                n_out.column        = '0;
            end
        endcase
    end

    // control state next values
    always_comb begin
        n_pend_valid = r_pend_valid;
        n_pend_cmd   = r_pend_cmd;
        n_pend_cnt   = r_pend_cnt;
        n_pend_line  = r_pend_line;
        n_pend_col   = r_pend_col;
        n_line       = r_line;
        n_col        = r_col;
        n_next_idx   = r_next_idx;
        n_sp         = r_sp;
        n_walk       = r_walk;
        n_failed     = r_failed;
        n_out_valid  = r_out_valid && !i_out_ready;

        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
        end
        if (i_cmd.emit && i_cmd.emit_sel == bml_pkg::E_FLUSH) begin
            n_pend_valid = 1'b0;
            n_next_idx   = r_next_idx + IB'(1);
        end
        if (i_cmd.emit && i_cmd.emit_sel == bml_pkg::E_BRACKET && !bracket_err) begin
            n_next_idx = r_next_idx + IB'(1);
        end
        if (i_cmd.merge) begin
            n_pend_cnt = r_pend_cnt + 16'd1;
        end
        if (i_cmd.load_pend) begin
            n_pend_valid = 1'b1;
            n_pend_cmd   = 3'(cur_cmd);
            n_pend_cnt   = 16'd1;
            n_pend_line  = r_line;
            n_pend_col   = r_col;
        end
        if (i_cmd.newline) begin
            if (r_line != bml_pkg::SAT16) n_line = r_line + 16'd1;
            n_col = '0;
        end
        if (i_cmd.col_inc && r_col != bml_pkg::SAT16) begin
            n_col = r_col + 16'd1;
        end
        if (i_cmd.push) n_sp = r_sp + SB'(1);
        if (i_cmd.pop)  n_sp = r_sp - SB'(1);
        if (i_cmd.set_fail) n_failed = 1'b1;
        if (i_cmd.walk_clr) n_walk = '0;
        if (i_cmd.walk_inc) n_walk = r_walk + SB'(1);
        if (i_cmd.clear_all) begin
            n_pend_valid = 1'b0;
            n_pend_cmd   = '0;
            n_pend_cnt   = '0;
            n_pend_line  = 16'd1;
            n_pend_col   = '0;
            n_line       = 16'd1;
            n_col        = '0;
            n_next_idx   = '0;
            n_sp         = '0;
            n_failed     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_pend_cmd   <= '0;
            r_pend_cnt   <= '0;
            r_pend_line  <= 16'd1;
            r_pend_col   <= '0;
            r_line       <= 16'd1;
            r_col        <= '0;
            r_next_idx   <= '0;
            r_sp         <= '0;
            r_walk       <= '0;
            r_failed     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_pend_valid <= n_pend_valid;
            r_pend_cmd   <= n_pend_cmd;
            r_pend_cnt   <= n_pend_cnt;
            r_pend_line  <= n_pend_line;
            r_pend_col   <= n_pend_col;
            r_line       <= n_line;
            r_col        <= n_col;
            r_next_idx   <= n_next_idx;
            r_sp         <= n_sp;
            r_walk       <= n_walk;
            r_failed     <= n_failed;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_kind <= i_in_data.kind;
            r_byte <= i_in_data.source_byte;
        end
        if (i_cmd.emit) begin
            r_out <= n_out;
        end
    end

    // open bracket stack, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            mem[AB'(r_sp)] <= '{index: r_next_idx, line: r_line, col: r_col};
        end
        r_rd_data <= mem[rd_addr];
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: sv/bracket_matching_run_length_lexer.sv
// a source byte is taken in idle and decoded in the next cycle; flush and token give any
// results, with output stalls; end item: flush, a read and an emit state per unmatched open
// in the stack memory, then end done (only end done after a failure)
// the decode/flush/token sequencer takes a new item only once the last is through; the
// stack memory has a single read port; reset (synchronous, active low) clears all counters
// and flags at once, the stack memory itself is not cleared
module bracket_matching_run_length_lexer (
    input logic        i_clk,
    input logic        i_rst_n,
    bml_in_if.sink     i_in,
    bml_out_if.source  o_out
);

    bml_pkg::t_dp_cmd cmd;
    bml_pkg::t_dp_sts sts;

    bml_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bml_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in.data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_out_data  (o_out.data)
    );

    // one item at a time: the input closes right after a transaction
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input taken while an item is still in work");

    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.status == bml_pkg::ST_END_DONE)
            |-> o_out.data.last_result)
        else $error("end done result without last flag");

    a_close_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.status == bml_pkg::ST_UNMATCHED_CLOSE)
            |-> (o_out.data.command == bml_pkg::CMD_CLOSE && o_out.data.last_result))
        else $error("unmatched close result malformed");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.push |-> !sts.stack_full)
        else $error("push into a full bracket stack");

endmodule

FILE: tb/sv/lexer_check_pkg.sv
`timescale 1ns / 100ps
// scoreboard class for the bracket matching run-length lexer: predicts the results of
// each accepted item and checks the results coming out; depends on bml_pkg
package lexer_check_pkg;
    import bml_pkg::*;

    localparam int MAX_REPORTS = 10;

    class lexer_scoreboard;
        t_out_item   expected_results[$];
        t_out_item   batch[$];
        int unsigned mismatches;
        int unsigned results_checked;
        int unsigned status_seen[8];

        // lexer state
        bit                    run_valid;
        t_cmd                  run_cmd;
        logic [15:0]           run_count;
        logic [15:0]           run_line;
        logic [15:0]           run_col;
        logic [15:0]           cur_line;
        logic [15:0]           cur_col;
        logic [INDEX_BITS-1:0] next_index;
        t_stack_entry          opens[STACK_DEPTH];
        int unsigned           depth;
        bit                    failed;

        function new();
            mismatches      = 0;
            results_checked = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
            foreach (opens[i]) opens[i] = '0;
            clear_state();
        endfunction

        function void clear_state();
            run_valid  = 1'b0;
            run_cmd    = CMD_PLUS;
            run_count  = 16'd0;
            run_line   = 16'd1;
            run_col    = 16'd0;
            cur_line   = 16'd1;
            cur_col    = 16'd0;
            next_index = '0;
            depth      = 0;
            failed     = 1'b0;
        endfunction

        function int unsigned outstanding();
            return expected_results.size();
        endfunction

        function void emit(t_status st, t_cmd cmd, logic [15:0] cnt, logic [15:0] idx,
                           logic [15:0] par, logic [15:0] ln, logic [15:0] col);
            t_out_item r;
            r.status        = st;
            r.command       = cmd;
            r.repeat_count  = cnt;
            r.token_index   = idx;
            r.partner_index = par;
            r.line_number   = ln;
            r.column        = col;
            r.last_result   = 1'b0;
            batch.push_back(r);
        endfunction

        function logic [15:0] take_index();
            logic [15:0] idx;
            idx = 16'(next_index);
            next_index++;
            return idx;
        endfunction

        function void flush_run();
            if (run_valid) begin
                emit(ST_TOKEN, run_cmd, run_count, take_index(), 16'd0, run_line, run_col);
                run_valid = 1'b0;
            end
        endfunction

        function bit decode(input logic [7:0] b, output t_cmd c);
            c = CMD_PLUS;
            case (b)
                CH_PLUS:   c = CMD_PLUS;
                CH_MINUS:  c = CMD_MINUS;
                CH_LT:     c = CMD_LEFT;
                CH_GT:     c = CMD_RIGHT;
                CH_COMMA:  c = CMD_IN;
                CH_DOT:    c = CMD_OUT;
                CH_AT:     c = CMD_AT;
                CH_LBRACK: c = CMD_OPEN;
                CH_RBRACK: c = CMD_CLOSE;
                default:   return 1'b0;
            endcase
            return 1'b1;
        endfunction

        // called once per accepted input transaction
        function void predict_item(logic kind, logic [7:0] b);
            t_cmd        cmd;
            logic [15:0] idx;
            batch.delete();
            if (kind) begin
                if (!failed) begin
                    flush_run();
                    for (int i = 0; i < depth; i++)
                        emit(ST_UNMATCHED_OPEN, CMD_OPEN, 16'd1, 16'(opens[i].index),
                             16'(opens[i].index), opens[i].line, opens[i].col);
                end
                emit(ST_END_DONE, CMD_PLUS, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
                clear_state();
            end else if (!failed) begin
                if (b == CH_NEWLINE) begin
                    if (cur_line != SAT16) cur_line++;
                    cur_col = 16'd0;
                end else begin
                    if (decode(b, cmd)) begin
                        if (cmd == CMD_OPEN) begin
                            flush_run();
                            if (depth >= STACK_DEPTH) begin
                                emit(ST_TOO_DEEP, CMD_OPEN, 16'd1, 16'd0, 16'd0,
                                     cur_line, cur_col);
                                failed = 1'b1;
                            end else begin
                                idx = take_index();
                                emit(ST_TOKEN, CMD_OPEN, 16'd1, idx, idx, cur_line, cur_col);
                                opens[depth].index = idx;
                                opens[depth].line  = cur_line;
                                opens[depth].col   = cur_col;
                                depth++;
                            end
                        end else if (cmd == CMD_CLOSE) begin
                            flush_run();
                            if (depth == 0) begin
                                emit(ST_UNMATCHED_CLOSE, CMD_CLOSE, 16'd1, 16'd0, 16'd0,
                                     cur_line, cur_col);
                                failed = 1'b1;
                            end else begin
                                depth--;
                                idx = take_index();
                                emit(ST_TOKEN, CMD_CLOSE, 16'd1, idx,
                                     16'(opens[depth].index), cur_line, cur_col);
                            end
                        end else if (run_valid && run_cmd == cmd && run_count != SAT16) begin
                            run_count++;
                        end else begin
                            // a full count lands here too and opens a fresh token
                            flush_run();
                            run_valid = 1'b1;
                            run_cmd   = cmd;
                            run_count = 16'd1;
                            run_line  = cur_line;
                            run_col   = cur_col;
                        end
                    end
                    if (cur_col != SAT16) cur_col++;
                end
            end
            if (batch.size() != 0) batch[batch.size() - 1].last_result = 1'b1;
            foreach (batch[i]) expected_results.push_back(batch[i]);
        endfunction

        function string show(t_out_item r);
            return $sformatf("st=%0d cmd=%0d cnt=%0d idx=%0d par=%0d line=%0d col=%0d last=%0b",
                             r.status, r.command, r.repeat_count, r.token_index,
                             r.partner_index, r.line_number, r.column, r.last_result);
        endfunction

        // called once per accepted output transaction
        function void check_result(t_out_item got);
            t_out_item exp;
            string     diff;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result at %0t: %s", $time, show(got));
                return;
            end
            exp = expected_results.pop_front();
            results_checked++;
            status_seen[int'(exp.status)]++;
            diff = "";
            if (got.status !== exp.status) diff = {diff, " status"};
            if (got.command !== exp.command) diff = {diff, " command"};
            if (got.repeat_count !== exp.repeat_count) diff = {diff, " repeat_count"};
            if (got.token_index !== exp.token_index) diff = {diff, " token_index"};
            if (got.partner_index !== exp.partner_index) diff = {diff, " partner_index"};
            if (got.line_number !== exp.line_number) diff = {diff, " line_number"};
            if (got.column !== exp.column) diff = {diff, " column"};
            if (got.last_result !== exp.last_result) diff = {diff, " last_result"};
            if (diff != "") begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("mismatch at %0t on%s", $time, diff);
                    $display("  expected %s", show(exp));
                    $display("  actual   %s", show(got));
                end
            end
        endfunction
    endclass

endpackage

FILE: tb/sv/bracket_matching_run_length_lexer_tb.sv
`timescale 1ns / 100ps
// top level testbench for bracket_matching_run_length_lexer: drives source bytes and end
// markers, randomizes both sides of the handshake; depends on bml_pkg, the channel
// interfaces and lexer_check_pkg
module bracket_matching_run_length_lexer_tb;
    import bml_pkg::*;
    import lexer_check_pkg::*;

    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 56;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bml_in_if  in_ch();
    bml_out_if out_ch();

    bracket_matching_run_length_lexer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    lexer_scoreboard sb;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_request   = 0;
    int unsigned hold_left      = 0;
    int unsigned idle_cycles    = 0;
    int unsigned live_items     = 0;
    int unsigned bytes_sent     = 0;
    int unsigned ends_sent      = 0;
    logic [7:0]  src_q[$];

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // result side: ready changes at the falling edge, long hold-offs counted here
    always @(negedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            out_ch.ready = 1'b0;
            hold_left--;
        end else begin
            out_ch.ready = ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("no transaction for %0d cycles, %0d results outstanding",
                         idle_cycles, sb.outstanding());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // entered and left at a falling edge
    task automatic send_item(input logic kind, input logic [7:0] b);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid            = 1'b1;
        in_ch.data.kind        = kind;
        in_ch.data.source_byte = b;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (kind || !sb.failed) live_items++;
        if (kind) ends_sent++;
        else bytes_sent++;
        sb.predict_item(kind, b);
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_item(1'b0, s[i]);
    endtask

    task automatic send_source();
        foreach (src_q[i]) send_item(1'b0, src_q[i]);
        src_q.delete();
        send_item(1'b1, 8'($urandom_range(255, 0)));
    endtask

    task automatic wait_results();
        in_ch.valid = 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] command_char(input int k);
        case (k)
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_LT;
            3:       return CH_GT;
            4:       return CH_COMMA;
            5:       return CH_DOT;
            6:       return CH_AT;
            7:       return CH_LBRACK;
            default: return CH_RBRACK;
        endcase
    endfunction

    // any byte the lexer skips without moving to a new line
    function automatic logic [7:0] filler_byte();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(255, 0));
        end while (b inside {CH_PLUS, CH_MINUS, CH_LT, CH_GT, CH_COMMA, CH_DOT, CH_AT,
                             CH_LBRACK, CH_RBRACK, CH_NEWLINE});
        return b;
    endfunction

    task automatic build_program(input int len, input int max_depth, input bit close_all);
        int         nest;
        int         pick;
        logic [7:0] c;
        nest = 0;
        repeat (len) begin
            pick = $urandom_range(99, 0);
            if (pick < 45) begin
                c = command_char($urandom_range(6, 0));
                repeat ($urandom_range(4, 1)) src_q.push_back(c);
            end else if (pick < 60 && nest < max_depth) begin
                src_q.push_back(CH_LBRACK);
                nest++;
            end else if (pick < 75 && nest > 0) begin
                src_q.push_back(CH_RBRACK);
                nest--;
            end else if (pick < 87) begin
                src_q.push_back(CH_NEWLINE);
            end else begin
                src_q.push_back(filler_byte());
            end
        end
        if (close_all) repeat (nest) src_q.push_back(CH_RBRACK);
    endtask

    task automatic build_noise(input int len);
        repeat (len) begin
            if ($urandom_range(1, 0)) src_q.push_back(command_char($urandom_range(8, 0)));
            else src_q.push_back(8'($urandom_range(255, 0)));
        end
    endtask

    task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct);
        int unsigned start;
        int          pick;
        int unsigned programs;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start          = live_items;
        programs       = 0;
        while (live_items - start < PHASE_ITEMS) begin
            pick = $urandom_range(99, 0);
            if (pick < 72) begin
                build_program($urandom_range(30, 4), $urandom_range(6, 1),
                              $urandom_range(3, 0) != 0);
            end else if (pick < 86) begin
                // well formed apart from one stray close
                build_program($urandom_range(20, 3), 4, 1'b1);
                src_q.insert($urandom_range(src_q.size(), 0), CH_RBRACK);
            end else begin
                build_noise($urandom_range(20, 3));
            end
            send_source();
            programs++;
            if (programs == 2) wait_results();
        end
        wait_results();
    endtask

    initial begin
        sb             = new();
        in_ch.valid    = 1'b0;
        in_ch.data     = '0;
        out_ch.ready   = 1'b0;
        i_rst_n        = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // every command, skipped bytes inside a run, then a close with nothing open
        send_text("++-<>,.@");
        send_item(1'b0, 8'h00);
        send_text("@\n@[]");
        send_item(1'b0, 8'hFF);
        send_text("]+");
        send_item(1'b1, 8'hFF);
        // opens left at the end, pending run flushed first
        send_text("[[\n]x+");
        send_item(1'b1, 8'h00);
        send_item(1'b1, 8'hA5);
        // nesting one past the stack, then a full stack reported at the end
        repeat (STACK_DEPTH + 1) send_item(1'b0, CH_LBRACK);
        send_item(1'b1, 8'h5A);
        repeat (STACK_DEPTH) send_item(1'b0, CH_LBRACK);
        send_item(1'b0, CH_PLUS);
        send_item(1'b1, 8'h00);
        wait_results();

        // receiver holds off while the sender keeps pushing until the input stalls
        hold_request = HOLD_CYCLES;
        repeat (40) begin
            src_q.push_back(CH_PLUS);
            src_q.push_back(CH_DOT);
        end
        src_q.push_back(CH_LBRACK);
        send_source();
        wait_results();

        run_phase(0, 0);
        run_phase(71, 0);
        run_phase(0, 71);
        run_phase(37, 37);

        in_ch.valid = 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.mismatches += sb.outstanding();

        $display("sent %0d source bytes and %0d end markers, checked %0d results",
                 bytes_sent, ends_sent, sb.results_checked);
        $display("tokens %0d, unmatched closes %0d, too deep %0d, unmatched opens %0d, ends %0d",
                 sb.status_seen[ST_TOKEN], sb.status_seen[ST_UNMATCHED_CLOSE],
                 sb.status_seen[ST_TOO_DEEP], sb.status_seen[ST_UNMATCHED_OPEN],
                 sb.status_seen[ST_END_DONE]);
        if (sb.mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
